[design/fp32m_pkg.sv]
// Shared types and constants for the split-significand single precision multiplier.
package fp32m_pkg;

  localparam logic [7:0]  EXP_MAX     = 8'd255;
  localparam logic [8:0]  EXP_BIAS    = 9'd127;
  localparam logic [8:0]  EXP_TOP     = 9'd254;
  localparam logic [25:0] ROUND_ADD   = 26'd2;

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_FIXED
  } kind_t;

  typedef struct packed {
    logic        sign;
    kind_t       kind;
    logic [7:0]  fixed_exp;
    logic [22:0] fixed_frac;
    logic [8:0]  esum;
  } ctrl_t;

endpackage

[design/fp32m_decode.sv]
// First stage: operand decoding, special case selection and partial products.
module fp32m_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  output logic                 vld_r,
  output fp32m_pkg::ctrl_t     ctrl_r,
  output logic [25:0]          hh_r,
  output logic [23:0]          hl_r,
  output logic [23:0]          lh_r
);
  import fp32m_pkg::*;

  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        a_zero, b_zero;
  logic [12:0] ah, bh;
  logic [10:0] al, bl;
  ctrl_t       ctrl_nxt;

  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    a_zero = (ea == 8'd0) && (fa == 23'd0);
    b_zero = (eb == 8'd0) && (fb == 23'd0);
    ah = {1'b1, fa[22:11]};
    bh = {1'b1, fb[22:11]};
    al = fa[10:0];
    bl = fb[10:0];
    ctrl_nxt.sign = a[31] ^ b[31];
    ctrl_nxt.kind = KIND_FIXED;
    ctrl_nxt.fixed_exp = 8'd0;
    ctrl_nxt.fixed_frac = 23'd0;
    ctrl_nxt.esum = {1'b0, ea} + {1'b0, eb};
    if (ea == EXP_MAX) begin
      ctrl_nxt.fixed_exp = EXP_MAX;
      ctrl_nxt.fixed_frac = {22'd0, b_zero};
    end else if (eb == EXP_MAX) begin
      ctrl_nxt.fixed_exp = EXP_MAX;
      ctrl_nxt.fixed_frac = {22'd0, a_zero};
    end else if (a_zero || b_zero) begin
      ctrl_nxt.fixed_frac = 23'd0;
    end else if (ea == 8'd0 || eb == 8'd0) begin
      ctrl_nxt.fixed_frac = 23'd1;
    end else begin
      ctrl_nxt.kind = KIND_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r <= ctrl_nxt;
      hh_r   <= ah * bh;
      hl_r   <= ah * bl;
      lh_r   <= al * bh;
    end
  end
endmodule

[design/fp32m_sum.sv]
// Second stage: partial product sum; the control word with its biased exponent sum passes through.
module fp32m_sum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  fp32m_pkg::ctrl_t     ctrl_in,
  input  logic [25:0]          hh,
  input  logic [23:0]          hl,
  input  logic [23:0]          lh,
  output logic                 vld_r,
  output fp32m_pkg::ctrl_t     ctrl_r,
  output logic [25:0]          sum_r
);
  import fp32m_pkg::*;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r <= ctrl_in;
      sum_r  <= hh + {13'd0, hl[23:11]} + {13'd0, lh[23:11]} + ROUND_ADD;
    end
  end
endmodule

[design/fp32m_norm.sv]
// Third stage: normalization, exponent range checks and result packing.
module fp32m_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  fp32m_pkg::ctrl_t     ctrl_in,
  input  logic [25:0]          sum,
  output logic                 vld_r,
  output logic [31:0]          product_r
);
  import fp32m_pkg::*;

  logic [8:0]  e;
  logic [7:0]  eo;
  logic [22:0] fo;
  logic [31:0] product_nxt;

  always_comb begin
    e  = ctrl_in.esum - EXP_BIAS;
    eo = 8'd0;
    fo = 23'd0;
    if (ctrl_in.kind == KIND_FIXED) begin
      eo = ctrl_in.fixed_exp;
      fo = ctrl_in.fixed_frac;
    end else if (ctrl_in.esum < EXP_BIAS) begin
      eo = 8'd0;
    end else if (e > EXP_TOP) begin
      eo = EXP_MAX;
    end else if (sum[25]) begin
      eo = e[7:0] + 8'd1;
      fo = (eo == EXP_MAX) ? 23'd0 : sum[24:2];
    end else if (e == 9'd0) begin
      eo = 8'd0;
    end else begin
      eo = e[7:0];
      fo = sum[23:1];
    end
    product_nxt = {ctrl_in.sign, eo, fo};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      product_r <= product_nxt;
    end
  end
endmodule

[design/fp32_multiply_split_mantissa.sv]
// An accepted word passes the decode, sum and norm registers on its way to out_product.
// Throughput: one word per cycle unless a valid output is stalled; the pipeline advances
// when its last stage is empty or being taken; in_stall is out_stall gated by out_valid.
// Reset: synchronous active-low rst_n clears all valid bits; data registers are not reset.
// Stages: decode and partial multiplies, partial sum, normalize and pack.
module fp32_multiply_split_mantissa (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_product
);
  import fp32m_pkg::*;

  logic        en;
  logic        v1, v2;
  ctrl_t       c1, c2;
  logic [25:0] hh, sum;
  logic [23:0] hl, lh;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  fp32m_decode u_decode (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(in_valid),
    .a(in_operand_a), .b(in_operand_b),
    .vld_r(v1), .ctrl_r(c1), .hh_r(hh), .hl_r(hl), .lh_r(lh)
  );

  fp32m_sum u_sum (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v1), .ctrl_in(c1),
    .hh(hh), .hl(hl), .lh(lh),
    .vld_r(v2), .ctrl_r(c2), .sum_r(sum)
  );

  fp32m_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v2), .ctrl_in(c2), .sum(sum),
    .vld_r(out_valid), .product_r(out_product)
  );

`ifndef NO_ASSERTIONS
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && !v1 && !v2 && !in_valid) |=> ##1 !v2)
    else $error("valid appeared without input");
  a_hold_product: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_product)))
    else $error("held product changed");
`endif
endmodule
